// ----- hdl/pfx_pkg.sv -----
// shared constants and types for the postfix expression evaluator
// no dependencies; used by pfx_div and postfix_expression_evaluator
package pfx_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SYM_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int DATA_OUT_W  = 40;

    // character codes
    localparam logic [SYM_W-1:0] SYM_COMMA   = 8'h2C;
    localparam logic [SYM_W-1:0] SYM_DOT     = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_STAR    = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH   = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO    = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE    = 8'h39;
    localparam logic [SYM_W-1:0] SYM_UPPER_A = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UPPER_Z = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_LOWER_A = 8'h61;
    localparam logic [SYM_W-1:0] SYM_LOWER_Z = 8'h7A;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_UNDERFLOW = 3'd1,
        STATUS_OVERFLOW  = 3'd2,
        STATUS_DIV_ZERO  = 3'd3,
        STATUS_UNKNOWN   = 3'd4
    } status_t;

endpackage

// ----- hdl/postfix_expression_evaluator.sv -----
// postfix (rpn) expression evaluator, one ascii character per input beat
// depends on pfx_pkg, pfx_ram (value stack) and pfx_div (shared divider)
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready | s_tdata[7:0] symbol
//  m_      | out       | m_tvalid/m_tready | m_tdata: top_value, status, stack_depth;
//          |           |                   | m_tlast: answer_valid
//
// states per beat: digits, letters, comma and '.' go idle, fin; + - * and '/'
// by zero go idle, opa, push, fin; unknown symbols go idle, opa, peek, fin, or
// skip peek when the pops empty the stack; '/' with a nonzero divisor waits in
// div for the one-bit-per-cycle divider between opa and push
// the stack lives in a 16-entry ram with one read and one write port; an
// operator reads operand a and, for unknown symbols, the new top through it
// reset (rst_n low, async) empties the stack and clears the number builder;
// no clearing pass, stale stack entries are never read
// s_tready is high only in the idle state; a finished result waits in the
// output register while the next beat is accepted, and the block stalls only
// when a new result is ready before the previous one is taken
module postfix_expression_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] top_value, [34:32] status, [39:35] stack_depth
    output logic        m_tlast    // answer_valid
);

    localparam int W      = pfx_pkg::VALUE_WIDTH;
    localparam int PTR_W  = pfx_pkg::PTR_W;
    localparam int ADDR_W = pfx_pkg::ADDR_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_OPA  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_PUSH = 6'b001000,
        ST_PEEK = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_OTHER
    } op_t;

    // sequencer and architectural state
    state_t           state_reg, state_next;
    logic [PTR_W-1:0] sp_reg, sp_next;
    logic [W-1:0]     top_reg, top_next;       // cached top of stack, 0 when empty
    logic [W-1:0]     acc_reg, acc_next;
    logic             stopped_reg, stopped_next;
    logic             after_op_reg, after_op_next;

    // per-item working registers
    pfx_pkg::status_t status_reg, status_next;
    logic             last_reg, last_next;
    op_t              op_reg, op_next;
    logic             under_reg, under_next;
    logic             have_a_reg, have_a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     r_reg, r_next;

    // output register
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [pfx_pkg::DATA_OUT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                              m_tlast_reg, m_tlast_next;

    // stack ram and divider hookup
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [W-1:0]      ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [W-1:0]      ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [W-1:0]      div_quotient;

    logic [PTR_W-1:0]  sp_minus1;
    logic [PTR_W-1:0]  sp_minus2;
    logic [W-1:0]      a_val;
    logic [3:0]        digit;
    logic              is_digit;
    logic              is_letter;
    logic              accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign sp_minus1 = sp_reg - PTR_W'(1);
    assign sp_minus2 = sp_reg - PTR_W'(2);
    assign a_val     = have_a_reg ? ram_rdata : '0;
    assign digit     = 4'(s_tdata - pfx_pkg::SYM_ZERO);
    assign is_digit  = (s_tdata >= pfx_pkg::SYM_ZERO) && (s_tdata <= pfx_pkg::SYM_NINE);
    assign is_letter = ((s_tdata >= pfx_pkg::SYM_UPPER_A) && (s_tdata <= pfx_pkg::SYM_UPPER_Z))
                    || ((s_tdata >= pfx_pkg::SYM_LOWER_A) && (s_tdata <= pfx_pkg::SYM_LOWER_Z));

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        acc_next      = acc_reg;
        stopped_next  = stopped_reg;
        after_op_next = after_op_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        op_next       = op_reg;
        under_next    = under_reg;
        have_a_next   = have_a_reg;
        b_next        = b_reg;
        r_next        = r_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        ram_we        = 1'b0;
        ram_waddr     = sp_reg[ADDR_W-1:0];
        ram_wdata     = acc_reg;
        ram_re        = 1'b0;
        ram_raddr     = sp_minus2[ADDR_W-1:0];
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = pfx_pkg::STATUS_OK;
                    last_next   = 1'b0;
                    state_next  = ST_FIN;
                    priority if (s_tdata == pfx_pkg::SYM_DOT)
                    begin
                        // answer is the current top; everything else clears
                        last_next     = 1'b1;
                        sp_next       = '0;
                        acc_next      = '0;
                        stopped_next  = 1'b0;
                        after_op_next = 1'b0;
                    end
                    else if (s_tdata == pfx_pkg::SYM_COMMA)
                    begin
                        if (after_op_reg)
                        begin
                            after_op_next = 1'b0;
                        end
                        else
                        begin
                            if (sp_reg < PTR_W'(pfx_pkg::STACK_DEPTH))
                            begin
                                ram_we   = 1'b1;
                                top_next = acc_reg;
                                sp_next  = sp_reg + PTR_W'(1);
                            end
                            else
                            begin
                                status_next = pfx_pkg::STATUS_OVERFLOW;
                            end
                            acc_next     = '0;
                            stopped_next = 1'b0;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (!stopped_reg)
                        begin
                            acc_next = (acc_reg << 3) + (acc_reg << 1) + W'(digit);
                        end
                    end
                    else if (is_letter)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        // operator: operand b is the cached top, fetch a from ram
                        unique case (s_tdata)
                            pfx_pkg::SYM_PLUS:  op_next = OP_ADD;
                            pfx_pkg::SYM_MINUS: op_next = OP_SUB;
                            pfx_pkg::SYM_STAR:  op_next = OP_MUL;
                            pfx_pkg::SYM_SLASH: op_next = OP_DIV;
                            default:            op_next = OP_OTHER;
                        endcase
                        b_next        = (sp_reg != '0) ? top_reg : '0;
                        have_a_next   = (sp_reg >= PTR_W'(2));
                        under_next    = (sp_reg < PTR_W'(2));
                        ram_re        = (sp_reg >= PTR_W'(2));
                        sp_next       = (sp_reg >= PTR_W'(2)) ? sp_minus2 : '0;
                        after_op_next = 1'b1;
                        state_next    = ST_OPA;
                    end
                end
            end

            ST_OPA:
            begin
                if (op_reg == OP_OTHER)
                begin
                    status_next = under_reg ? pfx_pkg::STATUS_UNDERFLOW
                                            : pfx_pkg::STATUS_UNKNOWN;
                    if (sp_reg != '0)
                    begin
                        // new top has to come back from the ram
                        ram_re     = 1'b1;
                        ram_raddr  = sp_minus1[ADDR_W-1:0];
                        state_next = ST_PEEK;
                    end
                    else
                    begin
                        top_next   = '0;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    acc_next     = '0;
                    stopped_next = 1'b0;
                    state_next   = ST_PUSH;
                    unique case (op_reg)
                        OP_ADD: r_next = a_val + b_reg;
                        OP_SUB: r_next = a_val - b_reg;
                        OP_MUL: r_next = W'(a_val * b_reg);
                        OP_DIV:
                        begin
                            if (b_reg == '0)
                            begin
                                r_next      = '0;
                                status_next = pfx_pkg::STATUS_DIV_ZERO;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: r_next = '0;
                    endcase
                    if (under_reg)
                    begin
                        status_next = pfx_pkg::STATUS_UNDERFLOW;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    r_next     = div_quotient;
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                // at most depth-2 after the pops, so the push always fits
                ram_we     = 1'b1;
                ram_wdata  = r_reg;
                top_next   = r_reg;
                sp_next    = sp_reg + PTR_W'(1);
                state_next = ST_FIN;
            end

            ST_PEEK:
            begin
                top_next   = ram_rdata;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'(sp_reg), status_reg, top_reg[31:0]};
                    m_tlast_next  = last_reg;
                    if (last_reg)
                    begin
                        top_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sp_reg       <= '0;
            top_reg      <= '0;
            acc_reg      <= '0;
            stopped_reg  <= 1'b0;
            after_op_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            top_reg      <= top_next;
            acc_reg      <= acc_next;
            stopped_reg  <= stopped_next;
            after_op_reg <= after_op_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        last_reg    <= last_next;
        op_reg      <= op_next;
        under_reg   <= under_next;
        have_a_reg  <= have_a_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    pfx_ram #(
        .WIDTH (W),
        .DEPTH (pfx_pkg::STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    pfx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_val),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // the stack pointer never passes the stack size
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PTR_W'(pfx_pkg::STACK_DEPTH))
        else $error("stack pointer beyond stack size");

    // the cached top reads zero whenever the stack is empty between beats
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && sp_reg == '0) |-> (top_reg == '0))
        else $error("cached top not zero on empty stack");

    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide wait");

    // an answer beat always reports an empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tlast_reg) |-> (m_tdata_reg[39:35] == 5'd0))
        else $error("answer beat with nonzero depth");

endmodule

// ----- hdl/pfx_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module pfx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/pfx_div.sv -----
// iterative signed divider, truncating toward zero, one quotient bit per cycle
// depends on pfx_pkg
module pfx_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pfx_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [pfx_pkg::VALUE_WIDTH-1:0] divisor,
    output logic                            done,
    output logic [pfx_pkg::VALUE_WIDTH-1:0] quotient
);

    localparam int W     = pfx_pkg::VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [W:0]       rem_shift;
    logic [W:0]       rem_diff;

    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            den_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            // restoring step: trial subtract of the shifted remainder
            if (!rem_diff[W])
            begin
                rem_next = rem_diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the postfix expression evaluator
// depends on pfx_pkg and postfix_expression_evaluator; carries its own stack predictor
// stimulus: a directed table first, then random expressions in three idling phases
module testbench;

    // one output beat as the block reports it
    typedef struct packed {
        logic [4:0]        depth;
        pfx_pkg::status_t  status;
        logic              answer;
        logic [31:0]       top;
    } stack_report_t;

    // directed row: symbol, whether the report is typed in, and that report
    typedef struct packed {
        logic [7:0]    sym;
        logic          pinned;
        stack_report_t want;
    } directed_row_t;

    localparam int N_DIRECTED   = 30;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 64;

    localparam logic [7:0]  SYM_TILDE = 8'h7E;
    localparam logic [31:0] MOST_NEG  = 32'h8000_0000;

    localparam stack_report_t EMPTY_UNDERFLOW =
        '{5'd0, pfx_pkg::STATUS_UNDERFLOW, 1'b0, 32'd0};
    localparam stack_report_t ZERO_PUSHED_UNDERFLOW =
        '{5'd1, pfx_pkg::STATUS_UNDERFLOW, 1'b0, 32'd0};
    localparam stack_report_t EMPTY_ANSWER    = '{5'd0, pfx_pkg::STATUS_OK, 1'b1, 32'd0};
    localparam stack_report_t UNCHECKED       = '0;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] symbol
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] top_value, [34:32] status, [39:35] stack_depth
    logic        m_tlast;           // answer_valid

    postfix_expression_evaluator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // directed walk: underflow on an empty stack with the byte extremes, a ten digit
    // number that wraps to the most negative value, a letter cutting a number short,
    // most negative divided by minus one, comma right after an operator, divide by
    // zero, an unknown symbol with two operands, and answers
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{pfx_pkg::SYM_PLUS,          1'b1, ZERO_PUSHED_UNDERFLOW},
        '{8'h00,                      1'b1, EMPTY_UNDERFLOW},
        '{8'hFF,                      1'b1, EMPTY_UNDERFLOW},
        '{pfx_pkg::SYM_DOT,           1'b1, EMPTY_ANSWER},
        '{pfx_pkg::SYM_ZERO + 8'd2,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd1,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd4,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd7,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd4,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd8,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd3,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd6,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd4,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd8,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_COMMA,         1'b1, '{5'd1, pfx_pkg::STATUS_OK, 1'b0, MOST_NEG}},
        '{pfx_pkg::SYM_COMMA,         1'b0, UNCHECKED},
        '{pfx_pkg::SYM_ZERO + 8'd1,   1'b0, UNCHECKED},
        '{pfx_pkg::SYM_LOWER_Z,       1'b0, UNCHECKED},
        '{pfx_pkg::SYM_NINE,          1'b0, UNCHECKED},
        '{pfx_pkg::SYM_COMMA,         1'b0, UNCHECKED},
        '{pfx_pkg::SYM_MINUS,         1'b0, UNCHECKED},
        '{pfx_pkg::SYM_SLASH,         1'b1, '{5'd1, pfx_pkg::STATUS_OK, 1'b0, MOST_NEG}},
        '{pfx_pkg::SYM_COMMA,         1'b0, UNCHECKED},
        '{pfx_pkg::SYM_COMMA,         1'b0, UNCHECKED},
        '{pfx_pkg::SYM_SLASH,         1'b1,
          '{5'd1, pfx_pkg::STATUS_DIV_ZERO, 1'b0, 32'd0}},
        '{pfx_pkg::SYM_COMMA,         1'b0, UNCHECKED},
        '{pfx_pkg::SYM_COMMA,         1'b0, UNCHECKED},
        '{SYM_TILDE,                  1'b1,
          '{5'd0, pfx_pkg::STATUS_UNKNOWN, 1'b0, 32'd0}},
        '{pfx_pkg::SYM_STAR,          1'b1,
          '{5'd1, pfx_pkg::STATUS_UNDERFLOW, 1'b0, 32'd0}},
        '{pfx_pkg::SYM_DOT,           1'b1, EMPTY_ANSWER}
    };

    // ---------------------------------------------------------------
    // stack predictor
    // ---------------------------------------------------------------
    logic [31:0] shadow_stack [pfx_pkg::STACK_DEPTH];
    int          shadow_depth    = 0;
    logic [31:0] shadow_number   = '0;
    bit          shadow_halted   = 1'b0;   // a letter ended the current token
    bit          shadow_after_op = 1'b0;   // next comma only clears this mark

    stack_report_t predicted_reports [$];

    function automatic logic [31:0] pop_operand(inout bit starved);
        if (shadow_depth == 0) begin
            starved = 1'b1;
            return '0;
        end
        shadow_depth--;
        return shadow_stack[shadow_depth];
    endfunction

    function automatic bit push_operand(input logic [31:0] value);
        if (shadow_depth >= pfx_pkg::STACK_DEPTH)
            return 1'b0;
        shadow_stack[shadow_depth] = value;
        shadow_depth++;
        return 1'b1;
    endfunction

    function automatic stack_report_t evaluate_symbol(input logic [7:0] sym);
        stack_report_t rep;
        logic [31:0]   lhs;
        logic [31:0]   rhs;
        logic [31:0]   outcome;
        logic [63:0]   lhs_mag;
        logic [63:0]   rhs_mag;
        logic [63:0]   quotient;
        bit            starved;
        bit            known;
        rep     = '0;
        starved = 1'b0;
        known   = 1'b1;
        outcome = '0;
        if (sym == pfx_pkg::SYM_DOT) begin
            // answer is the top before everything is cleared; a pending number is dropped
            rep.answer      = 1'b1;
            rep.top         = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
            shadow_depth    = 0;
            shadow_number   = '0;
            shadow_halted   = 1'b0;
            shadow_after_op = 1'b0;
            return rep;
        end
        if (sym == pfx_pkg::SYM_COMMA) begin
            if (shadow_after_op) begin
                shadow_after_op = 1'b0;
            end else begin
                if (!push_operand(shadow_number))
                    rep.status = pfx_pkg::STATUS_OVERFLOW;
                shadow_number = '0;
                shadow_halted = 1'b0;
            end
        end else if (sym >= pfx_pkg::SYM_ZERO && sym <= pfx_pkg::SYM_NINE) begin
            if (!shadow_halted)
                shadow_number = shadow_number * 10 + 32'(sym - pfx_pkg::SYM_ZERO);
        end else if ((sym >= pfx_pkg::SYM_UPPER_A && sym <= pfx_pkg::SYM_UPPER_Z) ||
                     (sym >= pfx_pkg::SYM_LOWER_A && sym <= pfx_pkg::SYM_LOWER_Z)) begin
            shadow_halted = 1'b1;
        end else begin
            // operand b comes off first
            rhs = pop_operand(starved);
            lhs = pop_operand(starved);
            case (sym)
                pfx_pkg::SYM_PLUS:  outcome = lhs + rhs;
                pfx_pkg::SYM_MINUS: outcome = lhs - rhs;
                pfx_pkg::SYM_STAR:  outcome = lhs * rhs;
                pfx_pkg::SYM_SLASH: begin
                    if (rhs == '0) begin
                        outcome    = '0;
                        rep.status = pfx_pkg::STATUS_DIV_ZERO;
                    end else begin
                        // truncating division on magnitudes, wide enough for -2^31 / -1
                        lhs_mag  = {{32{lhs[31]}}, lhs};
                        rhs_mag  = {{32{rhs[31]}}, rhs};
                        if (lhs[31])
                            lhs_mag = -lhs_mag;
                        if (rhs[31])
                            rhs_mag = -rhs_mag;
                        quotient = lhs_mag / rhs_mag;
                        if (lhs[31] ^ rhs[31])
                            quotient = -quotient;
                        outcome  = quotient[31:0];
                    end
                end
                default: begin
                    known      = 1'b0;
                    rep.status = pfx_pkg::STATUS_UNKNOWN;
                end
            endcase
            if (known) begin
                void'(push_operand(outcome));
                shadow_number = '0;
                shadow_halted = 1'b0;
            end
            if (starved)
                rep.status = pfx_pkg::STATUS_UNDERFLOW;
            shadow_after_op = 1'b1;
        end
        rep.top   = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
        rep.depth = 5'(shadow_depth);
        return rep;
    endfunction

    // ---------------------------------------------------------------
    // sender: drives at the falling edge, beat taken at the rising edge
    // ---------------------------------------------------------------
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int symbols_sent  = 0;

    // called at a falling edge, returns at a falling edge
    task automatic send_symbol(input logic [7:0] sym, input logic pinned,
                               input stack_report_t want);
        stack_report_t computed;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // predictor runs on every beat so its state tracks pinned rows too
        computed = evaluate_symbol(sym);
        predicted_reports.push_back(pinned ? want : computed);
        symbols_sent++;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // random expression builder
    // ---------------------------------------------------------------
    logic [7:0] expression_text [$];

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(3))
            0:       return pfx_pkg::SYM_PLUS;
            1:       return pfx_pkg::SYM_MINUS;
            2:       return pfx_pkg::SYM_STAR;
            default: return pfx_pkg::SYM_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(1) == 0)
            return 8'(pfx_pkg::SYM_UPPER_A + $urandom_range(25));
        return 8'(pfx_pkg::SYM_LOWER_A + $urandom_range(25));
    endfunction

    // mostly short numbers, some long enough to wrap, now and then cut by a letter
    task automatic append_operand();
        int pick;
        int digits;
        int k;
        pick = $urandom_range(99);
        if (pick < 30)
            digits = 1;
        else if (pick < 75)
            digits = $urandom_range(3, 2);
        else if (pick < 90)
            digits = $urandom_range(9, 4);
        else
            digits = $urandom_range(12, 10);
        for (k = 0; k < digits; k++) begin
            if ($urandom_range(19) == 0)
                expression_text.push_back(pick_letter());
            expression_text.push_back(8'(pfx_pkg::SYM_ZERO + $urandom_range(9)));
        end
        expression_text.push_back(pfx_pkg::SYM_COMMA);
    endtask

    task automatic compose_expression();
        int mode;
        int operands;
        int pushed;
        int depth_guess;
        int len;
        int k;
        expression_text.delete();
        mode = $urandom_range(99);
        if (mode < 70) begin
            // well-formed: operands and operators kept in balance, then an answer
            operands    = $urandom_range(7, 1);
            pushed      = 0;
            depth_guess = 0;
            while (pushed < operands || depth_guess > 1) begin
                if (pushed < operands && (depth_guess < 2 || $urandom_range(1) == 0)) begin
                    append_operand();
                    pushed++;
                    depth_guess++;
                end else begin
                    expression_text.push_back(pick_operator());
                    if ($urandom_range(1) == 0)
                        expression_text.push_back(pfx_pkg::SYM_COMMA);
                    depth_guess--;
                end
            end
            // sometimes a dangling number that the answer discards
            if ($urandom_range(9) == 0)
                expression_text.push_back(8'(pfx_pkg::SYM_ZERO + $urandom_range(9)));
            expression_text.push_back(pfx_pkg::SYM_DOT);
        end else if (mode < 80) begin
            // flood the stack with 15 to 19 operands, around its depth, then fold a little
            operands = $urandom_range(19, 15);
            for (k = 0; k < operands; k++)
                append_operand();
            len = $urandom_range(4, 1);
            for (k = 0; k < len; k++)
                expression_text.push_back(pick_operator());
            expression_text.push_back(pfx_pkg::SYM_DOT);
        end else begin
            // noise: any byte, plus commas, digits and operators in no order
            len = $urandom_range(10, 3);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(5))
                    0, 1, 2: expression_text.push_back(8'($urandom_range(255)));
                    3:       expression_text.push_back(pfx_pkg::SYM_COMMA);
                    4:       expression_text.push_back(8'(pfx_pkg::SYM_ZERO + $urandom_range(9)));
                    default: expression_text.push_back(pick_operator());
                endcase
            end
            if ($urandom_range(9) < 7)
                expression_text.push_back(pfx_pkg::SYM_DOT);
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off on request
    // ---------------------------------------------------------------
    int hold_ticket = 0;   // bumped by the stimulus to ask for a hold-off
    int hold_served = 0;
    int hold_left   = 0;

    always @(negedge clk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // result checker: every beat against the oldest prediction
    // ---------------------------------------------------------------
    int mismatch_count = 0;

    always @(posedge clk) begin
        stack_report_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (predicted_reports.size() == 0) begin
                $display("%0t: unexpected result beat, actual tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = predicted_reports.pop_front();
                if (m_tdata[31:0] !== want.top) begin
                    $display("%0t: top_value mismatch, expected %0d, actual %0d", $time,
                             $signed(want.top), $signed(m_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_tlast !== want.answer) begin
                    $display("%0t: answer_valid mismatch, expected %b, actual %b", $time,
                             want.answer, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[34:32] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             want.status, m_tdata[34:32]);
                    mismatch_count++;
                end
                if (m_tdata[39:35] !== want.depth) begin
                    $display("%0t: stack_depth mismatch, expected %0d, actual %0d", $time,
                             want.depth, m_tdata[39:35]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long without any beat on either side
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("postfix_expression_evaluator regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int row;
        int phase;
        int phase_end;
        int k;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 63;
        for (row = 0; row < N_DIRECTED; row++)
            send_symbol(directed_rows[row].sym, directed_rows[row].pinned,
                        directed_rows[row].want);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // sender pauses until the block has drained
                    s_tvalid <= 1'b0;
                    while (predicted_reports.size() != 0)
                        @(negedge clk);
                    // then the receiver holds off while beats keep coming, so the
                    // output register fills and s_tready drops
                    @(posedge clk);
                    hold_ticket++;
                    @(negedge clk);
                end
            endcase
            phase_end = symbols_sent + RANDOM_ITEMS / 3;
            while (symbols_sent < phase_end) begin
                compose_expression();
                for (k = 0; k < expression_text.size(); k++)
                    send_symbol(expression_text[k], 1'b0, UNCHECKED);
            end
        end

        s_tvalid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predicted_reports.size() != 0)
            $display("%0t: %0d results never arrived", $time, predicted_reports.size());
        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("postfix_expression_evaluator regression: pass");
        else
            $display("postfix_expression_evaluator regression: fail");
        $finish;
    end

endmodule
